### rtl/rrq_pkg.sv
// Package for the round-robin ready queue: sizes, item kinds, report outcomes
// and the controller/datapath command and status structs. No dependencies.
package rrq_pkg;
	localparam int MaxTasks = 16;
	localparam int SlotW = 4;
	localparam int CntW = 5;

	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_DISPATCH = 2'd2;
	localparam logic [1:0] KIND_REPORT = 2'd3;

	localparam logic [1:0] OUT_FINISHED = 2'd0;
	localparam logic [1:0] OUT_BLOCKED = 2'd1;

	localparam logic CFG_QUANTUM = 1'b0;
	localparam logic CFG_IDLE = 1'b1;

	typedef struct packed {
		logic load;    // look up list position and dispatch pick, read memories
		logic exec;    // multiply / accumulate, compute list updates
		logic commit;  // write list and memories, build result
	} rrq_cmd_t;

	typedef struct packed {
		logic dummy;
	} rrq_sts_t;
endpackage

### rtl/rrq_ram.sv
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
module rrq_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/rrq_ctrl.sv
// Controller: one-hot sequencer for load, exec, commit and result hold.
// Depends on rrq_pkg.
module rrq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output rrq_pkg::rrq_cmd_t cmd
);
	import rrq_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_LOAD   = 5'b00010,
		ST_EXEC   = 5'b00100,
		ST_COMMIT = 5'b01000,
		ST_OUT    = 5'b10000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign cmd.load = (state_q == ST_LOAD);
	assign cmd.exec = (state_q == ST_EXEC);
	assign cmd.commit = (state_q == ST_COMMIT);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_EXEC;
			ST_EXEC: state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_OUT;
			ST_OUT: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

### rtl/rrq_dp.sv
// Datapath: ready list, membership flags, weight/start/runtime memories and
// result registers. Depends on rrq_pkg and rrq_ram.
module rrq_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  rrq_pkg::rrq_cmd_t      cmd,
	input  logic                   cfg_we,
	input  logic                   cfg_idx,
	input  logic [15:0]            cfg_data,
	input  logic [1:0]             kind,
	input  logic [rrq_pkg::SlotW-1:0] slot,
	input  logic [7:0]             weight,
	input  logic [31:0]            tick_now,
	input  logic [1:0]             outcome,
	output logic                   accepted,
	output logic [rrq_pkg::SlotW-1:0] chosen_slot,
	output logic                   chosen_valid,
	output logic [31:0]            quantum_end,
	output logic [31:0]            run_total,
	output logic [rrq_pkg::CntW-1:0] ready_total
);
	import rrq_pkg::*;

	logic [15:0] quantum_q;
	logic [SlotW-1:0] idle_q;
	logic [SlotW-1:0] order_q [MaxTasks];
	logic [CntW-1:0] count_q;
	logic [MaxTasks-1:0] flags_q;
	logic [MaxTasks-1:0] rt_valid_q;

	logic [1:0] kind_q, outcome_q;
	logic [SlotW-1:0] slot_q;
	logic [7:0] weight_q;
	logic [31:0] tick_q;
	logic [SlotW-1:0] pick_q;
	logic [SlotW-1:0] pos_q;
	logic [31:0] prod_q;
	logic [31:0] rt_sum_q;

	// memory ports
	logic [SlotW-1:0] w_raddr, s_raddr;
	logic [7:0] w_rdata;
	logic [31:0] s_rdata, r_rdata, r_old;
	logic w_we, s_we, r_we;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= 16'd10;
			idle_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_QUANTUM: quantum_q <= cfg_data;
				CFG_IDLE: idle_q <= cfg_data[SlotW-1:0];
				default: ;
			endcase
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			slot_q <= slot;
			weight_q <= weight;
			tick_q <= tick_now;
			outcome_q <= outcome;
		end
	end

	// position search over the list and dispatch pick
	logic [SlotW-1:0] pos_d;
	always_comb begin
		pos_d = '0;
		for (int i = MaxTasks - 1; i >= 0; i--) begin
			if (CntW'(i) < count_q && order_q[i] == slot_q) begin
				pos_d = SlotW'(i);
			end
		end
	end

	logic [SlotW-1:0] pick_d;
	assign pick_d = (order_q[0] == idle_q && count_q > CntW'(1)) ? order_q[1] : order_q[0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q <= pos_d;
			pick_q <= pick_d;
		end
	end

	assign w_raddr = pick_d;
	assign s_raddr = slot_q;

	rrq_ram #(.Width(8), .Depth(MaxTasks)) u_weight (
		.clk(clk), .we(w_we), .waddr(slot_q), .wdata(weight_q),
		.raddr(w_raddr), .rdata(w_rdata)
	);
	rrq_ram #(.Width(32), .Depth(MaxTasks)) u_start (
		.clk(clk), .we(s_we), .waddr(pick_q), .wdata(tick_q),
		.raddr(s_raddr), .rdata(s_rdata)
	);
	rrq_ram #(.Width(32), .Depth(MaxTasks)) u_runtime (
		.clk(clk), .we(r_we), .waddr(slot_q), .wdata(rt_sum_q),
		.raddr(s_raddr), .rdata(r_rdata)
	);

	assign r_old = rt_valid_q[slot_q] ? r_rdata : 32'd0;

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			prod_q <= 32'(quantum_q) * 32'(w_rdata);
			rt_sum_q <= r_old + (tick_q - s_rdata);
		end
	end

	logic in_list, is_add, is_rem, is_disp, is_rep, do_add, do_unlink, do_append;
	assign in_list = flags_q[slot_q];
	assign is_add = (kind_q == KIND_ADD);
	assign is_rem = (kind_q == KIND_REMOVE);
	assign is_disp = (kind_q == KIND_DISPATCH);
	assign is_rep = (kind_q == KIND_REPORT);
	assign do_add = is_add && !in_list;
	assign do_unlink = (is_rem || is_rep) && in_list;
	assign do_append = is_rep && !(outcome_q == OUT_FINISHED || outcome_q == OUT_BLOCKED)
		&& count_q != '0;

	assign w_we = cmd.commit && do_add;
	assign s_we = cmd.commit && is_disp && count_q != '0;
	assign r_we = cmd.commit && is_rep;

	// list update: add inserts at the front; unlink shifts entries after pos down by one, then optional append
	logic [SlotW-1:0] order_d [MaxTasks];
	logic [CntW-1:0] count_d, count_u;
	logic [MaxTasks-1:0] flags_d;
	logic acc_d;
	always_comb begin
		for (int i = 0; i < MaxTasks; i++) order_d[i] = order_q[i];
		count_d = count_q;
		flags_d = flags_q;
		count_u = count_q;
		acc_d = 1'b0;
		if (do_add) begin
			for (int i = 1; i < MaxTasks; i++) order_d[i] = order_q[i-1];
			order_d[0] = slot_q;
			count_d = count_q + CntW'(1);
			flags_d[slot_q] = 1'b1;
			acc_d = 1'b1;
		end else if (is_disp) begin
			acc_d = (count_q != '0);
		end else if (is_rem || is_rep) begin
			if (do_unlink) begin
				for (int i = 0; i < MaxTasks - 1; i++) begin
					if (SlotW'(i) >= pos_q) order_d[i] = order_q[i+1];
				end
				count_u = count_q - CntW'(1);
				flags_d[slot_q] = 1'b0;
				acc_d = 1'b1;
			end
			count_d = count_u;
			if (do_append) begin
				order_d[count_u[SlotW-1:0]] = slot_q;
				count_d = count_u + CntW'(1);
				flags_d[slot_q] = 1'b1;
				acc_d = 1'b1;
			end else if (is_rep && !(outcome_q == OUT_FINISHED || outcome_q == OUT_BLOCKED)) begin
				acc_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			flags_q <= '0;
			rt_valid_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_d;
			flags_q <= flags_d;
			if (is_rep) rt_valid_q[slot_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int i = 0; i < MaxTasks; i++) order_q[i] <= order_d[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			accepted <= acc_d;
			chosen_valid <= is_disp && count_q != '0;
			chosen_slot <= is_rep ? slot_q : ((is_disp && count_q != '0) ? pick_q : '0);
			quantum_end <= (is_disp && count_q != '0)
				? tick_q + ((prod_q == '0) ? 32'd1 : prod_q) : 32'd0;
			run_total <= is_rep ? rt_sum_q : 32'd0;
			ready_total <= count_d;
		end
	end
endmodule

### rtl/round_robin_ready_queue.sv
// Top level of the round-robin ready queue: controller plus datapath.
// Depends on rrq_pkg, rrq_ctrl, rrq_dp.
//
// Usage: one valid/ready input channel carries an item (kind, slot, weight,
// tick_now, outcome); one valid/ready output channel returns exactly one
// result per item. Kinds: add to front, remove, dispatch, report run.
// A plain write port (cfg_we, cfg_index, cfg_data) sets quantum_ticks (0)
// and idle_slot (1); write it only while the block is idle.
// An item is taken in the idle state and passes load, exec and commit
// before the result is valid. One item is in flight at a time: the idle
// state that takes the item, load, exec, commit and the output state that
// holds until the result is taken are the steps for each item; the
// list shift and the quantum multiply each own one of those steps.
// Reset empties the list, clears runtimes and restores quantum 10 and idle
// slot 0. When the receiver stalls, the result holds and in_ready stays low
// until it is taken.
module round_robin_ready_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [3:0]  slot,
	input  logic [7:0]  weight,
	input  logic [31:0] tick_now,
	input  logic [1:0]  outcome,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic [3:0]  chosen_slot,
	output logic        chosen_valid,
	output logic [31:0] quantum_end,
	output logic [31:0] run_total,
	output logic [4:0]  ready_total,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import rrq_pkg::*;

	rrq_cmd_t cmd;

	rrq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
	);

	rrq_dp u_dp (
		.clk(clk), .arst_n(arst_n), .accept(in_valid && in_ready), .cmd(cmd),
		.cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
		.kind(kind), .slot(slot), .weight(weight), .tick_now(tick_now),
		.outcome(outcome), .accepted(accepted), .chosen_slot(chosen_slot),
		.chosen_valid(chosen_valid), .quantum_end(quantum_end),
		.run_total(run_total), .ready_total(ready_total)
	);
endmodule

### rtl/rrq_checker.sv
// Port-level checker for round_robin_ready_queue, bound to the top level.
// Depends on the top level's ports only.
module rrq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        accepted,
	input logic        chosen_valid,
	input logic [31:0] quantum_end,
	input logic [4:0]  ready_total
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> ##3 out_valid) else $error("result late");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ready_total <= 5'd16) else $error("list count over size");
	a_disp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && chosen_valid) |-> (accepted && ready_total != 5'd0))
		else $error("dispatch without ready task");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(quantum_end)))
		else $error("result dropped under stall");
endmodule

bind round_robin_ready_queue rrq_checker u_rrq_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .accepted(accepted),
	.chosen_valid(chosen_valid), .quantum_end(quantum_end),
	.ready_total(ready_total)
);
